/* hdl/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg
// shared constants, command/status types and state codes for the periodic
// sample statistics block
// ----------------------------------------------------------------------------
package pss_pkg;

   localparam int SAMPLE_BITS = 32;
   localparam int FRAC_BITS   = 8;

   localparam int COUNT_BITS  = 32;
   localparam int ACC_BITS    = 64;
   localparam int OUT_BITS    = 40;
   localparam int PERIOD_BITS = 32;
   localparam int STAT_BITS   = 2;

   // count * sum of squares stays below 2^(COUNT_BITS+ACC_BITS)
   localparam int DIFF_BITS   = COUNT_BITS + ACC_BITS;
   localparam int DIV_BITS    = DIFF_BITS + 2 * FRAC_BITS;
   localparam int ROOT_BITS   = DIV_BITS / 2;
   localparam int MAC_BITS    = 2 * ACC_BITS + 2;
   localparam int CNT_BITS    = $clog2(DIV_BITS);

   localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(1000);

   localparam logic [STAT_BITS-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_BITS-1:0] STAT_EMPTY   = 2'd1;
   localparam logic [STAT_BITS-1:0] STAT_SINGLE  = 2'd2;

   // multiply sequence: count*sq, minus sum*sum, then the divisor count*(count-1)
   localparam logic [2:0] MUL_CSQ_LO  = 3'd0;
   localparam logic [2:0] MUL_CSQ_HI  = 3'd1;
   localparam logic [2:0] MUL_SS_LL   = 3'd2;
   localparam logic [2:0] MUL_SS_LH   = 3'd3;
   localparam logic [2:0] MUL_SS_HL   = 3'd4;
   localparam logic [2:0] MUL_SS_HH   = 3'd5;
   localparam logic [2:0] MUL_DIVISOR = 3'd6;
   localparam int         MUL_OPS     = 7;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_MUL      = 7'b0000010,
      ST_DIV_MEAN = 7'b0000100,
      ST_VAR_CHK  = 7'b0001000,
      ST_DIV_VAR  = 7'b0010000,
      ST_SQRT     = 7'b0100000,
      ST_DONE     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic       csr_write;
      logic       take_sample;
      logic       take_tick;
      logic       mul_issue;
      logic [2:0] mul_op;
      logic       div_load_mean;
      logic       div_load_var;
      logic       div_step;
      logic       sqrt_step;
      logic       save_mean;
      logic       out_load;
      logic       clear;
   } pss_cmd_type;

   typedef struct packed {
      logic report_due;
      logic var_pos;
   } pss_stat_type;

endpackage

/* hdl/pss_ctrl.sv */
// ----------------------------------------------------------------------------
// pss_ctrl
// sequencer: accumulate, multiply, divide for the mean, divide and square root
// for the deviation when the variance term is positive, then load the report register
// ----------------------------------------------------------------------------
module pss_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   input  logic                  csr_valid,
   input  logic                  rsp_stall,
   input  pss_pkg::pss_stat_type stat,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output pss_pkg::pss_cmd_type  cmd
);

   pss_pkg::state_type state_ff, state_in;
   logic [pss_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic take;
   logic out_free;

   assign req_stall = (state_ff != pss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign take      = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.csr_write = csr_valid;
      cmd.mul_op    = cnt_ff[2:0];
      case (state_ff)
         pss_pkg::ST_IDLE: begin
            if (take) begin
               cmd.take_tick   = req_kind;
               cmd.take_sample = !req_kind;
               if (!req_kind && stat.report_due) begin
                  state_in = pss_pkg::ST_MUL;
                  cnt_in   = '0;
               end
            end
         end
         pss_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pss_pkg::CNT_BITS'(pss_pkg::MUL_OPS)) begin
               cmd.div_load_mean = 1'b1;
               cnt_in   = '0;
               state_in = pss_pkg::ST_DIV_MEAN;
            end else begin
               cmd.mul_issue = 1'b1;
            end
         end
         pss_pkg::ST_DIV_MEAN: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pss_pkg::CNT_BITS'(pss_pkg::DIV_BITS - 1)) begin
               cnt_in   = '0;
               state_in = pss_pkg::ST_VAR_CHK;
            end
         end
         pss_pkg::ST_VAR_CHK: begin
            cmd.save_mean = 1'b1;
            if (stat.var_pos) begin
               cmd.div_load_var = 1'b1;
               state_in = pss_pkg::ST_DIV_VAR;
            end else begin
               state_in = pss_pkg::ST_DONE;
            end
         end
         pss_pkg::ST_DIV_VAR: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pss_pkg::CNT_BITS'(pss_pkg::DIV_BITS - 1)) begin
               cnt_in   = '0;
               state_in = pss_pkg::ST_SQRT;
            end
         end
         pss_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == pss_pkg::CNT_BITS'(pss_pkg::ROOT_BITS - 1)) begin
               cnt_in   = '0;
               state_in = pss_pkg::ST_DONE;
            end
         end
         pss_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = pss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pss_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pss_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/pss_dp.sv */
// ----------------------------------------------------------------------------
// pss_dp
// datapath: accumulators, shared 32x32 multiplier with accumulator,
// bit-serial divider, two-bit-a-step square root and report register
// ----------------------------------------------------------------------------
module pss_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pss_pkg::pss_cmd_type                  cmd,
   input  logic [pss_pkg::SAMPLE_BITS-1:0]       req_sample,
   input  logic [pss_pkg::PERIOD_BITS-1:0]       csr_data,
   output pss_pkg::pss_stat_type                 stat,
   output logic [pss_pkg::COUNT_BITS-1:0]        rsp_sample_count,
   output logic [pss_pkg::OUT_BITS-1:0]          rsp_mean_fixed,
   output logic [pss_pkg::OUT_BITS-1:0]          rsp_stddev_fixed,
   output logic [pss_pkg::SAMPLE_BITS-1:0]       rsp_minimum,
   output logic [pss_pkg::SAMPLE_BITS-1:0]       rsp_maximum,
   output logic [pss_pkg::STAT_BITS-1:0]         rsp_status
);

   localparam int SB = pss_pkg::SAMPLE_BITS;
   localparam int CB = pss_pkg::COUNT_BITS;
   localparam int AB = pss_pkg::ACC_BITS;
   localparam int OB = pss_pkg::OUT_BITS;
   localparam int DB = pss_pkg::DIV_BITS;
   localparam int RB = pss_pkg::ROOT_BITS;
   localparam int MB = pss_pkg::MAC_BITS;
   localparam int HB = AB / 2;

   logic [pss_pkg::PERIOD_BITS-1:0] period_ff;
   logic [CB-1:0] count_ff;
   logic [AB-1:0] sum_ff, sq_ff;
   logic [SB-1:0] min_ff, max_ff;
   logic [pss_pkg::PERIOD_BITS-1:0] ticks_ff;

   logic [AB-1:0] x_sq;

   logic [HB-1:0] mx, my;
   logic [AB-1:0] prod_ff;
   logic          mvld_ff;
   logic [2:0]    mop_ff;
   logic [MB-1:0] mac_ff, term;
   logic [AB-1:0] divv_ff;

   logic [DB-1:0] q_ff, q_in;
   logic [AB-1:0] d_ff, rem_ff, rem_in;
   logic [AB:0]   rem_sh;
   logic          rem_ge;

   logic [RB+1:0] srem_ff, srem_in;
   logic [RB-1:0] root_ff, root_in;
   logic [RB+3:0] s_sh, s_trial;

   logic [OB-1:0] mean_ff;

   logic [CB-1:0] cnt_m1;

   assign x_sq   = AB'(req_sample) * AB'(req_sample);
   assign cnt_m1 = count_ff - 1'b1;

   assign stat.report_due = (ticks_ff >= period_ff);
   assign stat.var_pos    = (count_ff > CB'(1)) && !mac_ff[MB-1] && (mac_ff != '0);

   // operand select for the shared multiplier
   always_comb begin
      mx = '0;
      my = '0;
      case (cmd.mul_op)
         pss_pkg::MUL_CSQ_LO:  begin mx = HB'(count_ff); my = sq_ff[HB-1:0];  end
         pss_pkg::MUL_CSQ_HI:  begin mx = HB'(count_ff); my = sq_ff[AB-1:HB]; end
         pss_pkg::MUL_SS_LL:   begin mx = sum_ff[HB-1:0];  my = sum_ff[HB-1:0];  end
         pss_pkg::MUL_SS_LH:   begin mx = sum_ff[HB-1:0];  my = sum_ff[AB-1:HB]; end
         pss_pkg::MUL_SS_HL:   begin mx = sum_ff[AB-1:HB]; my = sum_ff[HB-1:0];  end
         pss_pkg::MUL_SS_HH:   begin mx = sum_ff[AB-1:HB]; my = sum_ff[AB-1:HB]; end
         pss_pkg::MUL_DIVISOR: begin mx = HB'(count_ff); my = HB'(cnt_m1); end
         default: begin mx = '0; my = '0; end
      endcase
   end

   always_comb begin
      term = MB'(prod_ff);
      case (mop_ff)
         pss_pkg::MUL_CSQ_HI, pss_pkg::MUL_SS_LH, pss_pkg::MUL_SS_HL: term = MB'(prod_ff) << HB;
         pss_pkg::MUL_SS_HH: term = MB'(prod_ff) << AB;
         default: term = MB'(prod_ff);
      endcase
   end

   // restoring divide step
   always_comb begin
      rem_sh = {rem_ff, q_ff[DB-1]};
      rem_ge = (rem_sh >= {1'b0, d_ff});
      rem_in = rem_ge ? AB'(rem_sh - {1'b0, d_ff}) : rem_sh[AB-1:0];
      q_in   = {q_ff[DB-2:0], rem_ge};
   end

   // square root step, two radicand bits a step
   always_comb begin
      s_sh    = {srem_ff, q_ff[DB-1 -: 2]};
      s_trial = {2'b00, root_ff, 2'b01};
      if (s_sh >= s_trial) begin
         srem_in = (RB + 2)'(s_sh - s_trial);
         root_in = {root_ff[RB-2:0], 1'b1};
      end else begin
         srem_in = s_sh[RB+1:0];
         root_in = {root_ff[RB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= pss_pkg::PERIOD_RESET;
         count_ff  <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
         min_ff    <= '1;
         max_ff    <= '0;
         ticks_ff  <= '0;
         mvld_ff   <= 1'b0;
      end else begin
         if (cmd.csr_write) begin
            period_ff <= csr_data;
         end
         if (cmd.clear) begin
            count_ff <= '0;
            sum_ff   <= '0;
            sq_ff    <= '0;
            min_ff   <= '1;
            max_ff   <= '0;
            ticks_ff <= '0;
         end else if (cmd.take_sample) begin
            if (count_ff != '1) count_ff <= count_ff + 1'b1;
            sum_ff <= sum_ff + AB'(req_sample);
            sq_ff  <= sq_ff + x_sq;
            if (req_sample < min_ff) min_ff <= req_sample;
            if (req_sample > max_ff) max_ff <= req_sample;
         end else if (cmd.take_tick) begin
            if (ticks_ff != '1) ticks_ff <= ticks_ff + 1'b1;
         end
         mvld_ff <= cmd.mul_issue;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= AB'(mx) * AB'(my);
      mop_ff  <= cmd.mul_op;
      if (mvld_ff) begin
         case (mop_ff)
            pss_pkg::MUL_CSQ_LO:  mac_ff  <= term;
            pss_pkg::MUL_CSQ_HI:  mac_ff  <= mac_ff + term;
            pss_pkg::MUL_DIVISOR: divv_ff <= prod_ff;
            default:              mac_ff  <= mac_ff - term;
         endcase
      end

      if (cmd.div_load_mean) begin
         q_ff   <= DB'(sum_ff) << pss_pkg::FRAC_BITS;
         d_ff   <= AB'(count_ff);
         rem_ff <= '0;
      end else if (cmd.div_load_var) begin
         q_ff   <= DB'(mac_ff[pss_pkg::DIFF_BITS-1:0]) << (2 * pss_pkg::FRAC_BITS);
         d_ff   <= divv_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end else if (cmd.sqrt_step) begin
         q_ff <= q_ff << 2;
      end

      if (cmd.save_mean) begin
         mean_ff <= (|q_ff[DB-1:OB]) ? '1 : q_ff[OB-1:0];
         srem_ff <= '0;
         root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         srem_ff <= srem_in;
         root_ff <= root_in;
      end

      if (cmd.out_load) begin
         if (count_ff == '0) begin
            rsp_sample_count <= '0;
            rsp_mean_fixed   <= '0;
            rsp_stddev_fixed <= '0;
            rsp_minimum      <= '0;
            rsp_maximum      <= '0;
            rsp_status       <= pss_pkg::STAT_EMPTY;
         end else begin
            rsp_sample_count <= count_ff;
            rsp_mean_fixed   <= mean_ff;
            rsp_stddev_fixed <= (|root_ff[RB-1:OB]) ? '1 : root_ff[OB-1:0];
            rsp_minimum      <= min_ff;
            rsp_maximum      <= max_ff;
            rsp_status       <= (count_ff == CB'(1)) ? pss_pkg::STAT_SINGLE : pss_pkg::STAT_OK;
         end
      end
   end

endmodule

/* hdl/periodic_sample_stats.sv */
// ----------------------------------------------------------------------------
// periodic_sample_stats
// running count, mean, sample deviation, min and max with periodic report
// ----------------------------------------------------------------------------
// req channel: one beat is a sample (req_kind 0) or one time tick (req_kind 1);
//   a beat is taken when req_valid is high and req_stall is low
// a sample or tick beat is absorbed in the cycle it is taken; a sample that arrives once
//   the elapsed ticks reach the period starts a report and raises req_stall
// report sequence from the sample beat to rsp_valid: multiply, mean divide,
//   variance check, variance divide, square root, then report load; the
//   variance divide and square root are skipped when the variance term is
//   zero or one sample only
// rsp channel: report held in an output register, rsp_stall holds it; the
//   block takes new beats while a report waits, and a second report waits
//   in its last step until the register frees
// csr channel: csr_data writes report_period, csr_ready is always high
// reset: synchronous; period 1000, statistics cleared, min all ones
// ----------------------------------------------------------------------------
module periodic_sample_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [pss_pkg::SAMPLE_BITS-1:0]     req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pss_pkg::COUNT_BITS-1:0]      rsp_sample_count,
   output logic [pss_pkg::OUT_BITS-1:0]        rsp_mean_fixed,
   output logic [pss_pkg::OUT_BITS-1:0]        rsp_stddev_fixed,
   output logic [pss_pkg::SAMPLE_BITS-1:0]     rsp_minimum,
   output logic [pss_pkg::SAMPLE_BITS-1:0]     rsp_maximum,
   output logic [pss_pkg::STAT_BITS-1:0]       rsp_status,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pss_pkg::PERIOD_BITS-1:0]     csr_data
);

   pss_pkg::pss_cmd_type  cmd;
   pss_pkg::pss_stat_type stat;

   // the user keeps config changes to idle only; the block does not enforce this and always takes writes
   assign csr_ready = 1'b1;

   // sequencer
   pss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .csr_valid (csr_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // accumulators, arithmetic units and report register
   pss_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_sample       (req_sample),
      .csr_data         (csr_data),
      .stat             (stat),
      .rsp_sample_count (rsp_sample_count),
      .rsp_mean_fixed   (rsp_mean_fixed),
      .rsp_stddev_fixed (rsp_stddev_fixed),
      .rsp_minimum      (rsp_minimum),
      .rsp_maximum      (rsp_maximum),
      .rsp_status       (rsp_status)
   );

endmodule

/* hdl/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker
// port-level checks for the periodic sample statistics block
// ----------------------------------------------------------------------------
module pss_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                req_kind,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [pss_pkg::COUNT_BITS-1:0]      rsp_sample_count,
   input logic [pss_pkg::OUT_BITS-1:0]        rsp_stddev_fixed,
   input logic [pss_pkg::SAMPLE_BITS-1:0]     rsp_minimum,
   input logic [pss_pkg::SAMPLE_BITS-1:0]     rsp_maximum,
   input logic [pss_pkg::STAT_BITS-1:0]       rsp_status
);

   // stalled report beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("report dropped while stalled");

   // a tick beat never starts a report
   a_tick_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind |=> !req_stall)
      else $error("stall after tick beat");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pss_pkg::STAT_SINGLE) |->
         (rsp_stddev_fixed == '0) && (rsp_sample_count == pss_pkg::COUNT_BITS'(1)))
      else $error("single-sample report inconsistent");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pss_pkg::STAT_EMPTY) |-> rsp_minimum <= rsp_maximum)
      else $error("minimum above maximum");

endmodule

bind periodic_sample_stats pss_checker u_pss_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_kind         (req_kind),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_sample_count (rsp_sample_count),
   .rsp_stddev_fixed (rsp_stddev_fixed),
   .rsp_minimum      (rsp_minimum),
   .rsp_maximum      (rsp_maximum),
   .rsp_status       (rsp_status)
);
